@@ src/rvc_pkg.sv @@
// Package for the RV32I step core: payload structs, status and op codes,
// opcode constants and the memory map. No dependencies.
package rvc_pkg;

  localparam int unsigned MemBytesDefault = 65536;
  localparam logic [31:0] MemBase = 32'h8000_0000;
  localparam logic [31:0] EntryPcReset = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_EXEC  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ECALL    = 3'd1,
    ST_PC_ZERO  = 3'd2,
    ST_EBREAK   = 3'd3,
    ST_MISALIGN = 3'd4,
    ST_BOUNDS   = 3'd5,
    ST_HALTED   = 3'd6
  } status_t;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] F7_ALT     = 7'b0100000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] mem_address;
    logic [31:0] mem_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] executed_pc;
    logic [31:0] instruction_word;
    logic [4:0]  dest_register;
    logic [31:0] dest_value;
    logic [31:0] a0_value;
  } out_item_t;

endpackage

@@ src/rvc_front.sv @@
// Front end: accepts items into a two-entry queue.
// Depends on rvc_pkg.
module rvc_front import rvc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     q_valid,
  output in_item_t q_item,
  input  logic     q_pop
);

  in_item_t  slot [2];
  logic      rd_ptr, wr_ptr;
  logic [1:0] count;
  logic      push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> !q_pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !(q_pop && q_valid)) |=> count == $past(count) + 2'd1)
    else $error("push lost");

endmodule

@@ src/rvc_back.sv @@
// Back end: register file, program counter, byte memory and the execution
// sequencer. Depends on rvc_pkg.
module rvc_back import rvc_pkg::*; #(
  parameter int unsigned MEM_BYTES = MemBytesDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic [31:0] entry_pc,
  input  logic      q_valid,
  input  in_item_t  q_item,
  output logic      q_pop,
  output logic      res_valid,
  output out_item_t res_item,
  input  logic      res_take
);

  localparam int unsigned WordsN = MEM_BYTES / 4;
  localparam int unsigned WaW = (WordsN > 1) ? $clog2(WordsN) : 1;
  localparam int unsigned OffW = WaW + 2;

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_MEM} bstate_t;

  bstate_t   state, state_next;
  logic [31:0] regs [32];
  logic [31:0] pc;
  logic        halted;
  logic [31:0] rdata;
  logic [31:0] rlane;
  logic [1:0]  rsel;
  logic [OffW-1:0] raddr;
  logic        we;
  logic [OffW-1:0] waddr;
  logic [3:0]  wbe;
  logic [31:0] wdata;
  logic [3:0]  wbe_rot;
  logic [31:0] wdata_rot;
  logic [31:0] instr;

  // Byte i of an access at offset k lives in bank (k + i) mod 4, one row
  // further on for the banks below k; rotate data and enables to match.
  assign wbe_rot = (wbe << waddr[1:0]) | (wbe >> (3'd4 - {1'b0, waddr[1:0]}));
  assign wdata_rot = (wdata << {waddr[1:0], 3'b000}) |
                     (wdata >> (6'd32 - {1'b0, waddr[1:0], 3'b000}));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] mem [WordsN];
    logic [7:0] q;
    logic [WaW-1:0] wrow, rrow;
    assign wrow = waddr[OffW-1:2] + WaW'(2'(b) < waddr[1:0]);
    assign rrow = raddr[OffW-1:2] + WaW'(2'(b) < raddr[1:0]);
    always_ff @(posedge clk) begin
      if (we && wbe_rot[b]) mem[wrow] <= wdata_rot[8*b +: 8];
      q <= mem[rrow];
    end
    assign rlane[8*b +: 8] = q;
  end

  always_ff @(posedge clk) begin
    rsel <= raddr[1:0];
  end

  assign rdata = (rlane >> {rsel, 3'b000}) | (rlane << (6'd32 - {1'b0, rsel, 3'b000}));

  function automatic logic in_win(input logic [31:0] a, input logic [2:0] sz);
    logic [32:0] off;
    off = {1'b0, a - MemBase} + {30'd0, sz};
    return off <= 33'(MEM_BYTES);
  endfunction

  // Decode from the fetched word
  logic [31:0] w;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [31:0] rs1v, rs2v, i_imm, s_imm, u_imm, b_imm, j_imm;
  logic        alt;
  logic [31:0] opb, alu_r, addr_ls, next_pc, val;
  logic        taken, wr;
  logic [2:0]  lsize, ssize;
  logic [4:0]  sh;

  assign w     = state == S_FETCH ? rdata : instr;
  assign opc   = w[6:0];
  assign f3    = w[14:12];
  assign rd    = w[11:7];
  assign rs1v  = (w[19:15] == 5'd0) ? 32'd0 : regs[w[19:15]];
  assign rs2v  = (w[24:20] == 5'd0) ? 32'd0 : regs[w[24:20]];
  assign i_imm = {{20{w[31]}}, w[31:20]};
  assign s_imm = {{20{w[31]}}, w[31:25], w[11:7]};
  assign u_imm = {w[31:12], 12'd0};
  assign b_imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign j_imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign alt   = w[31:25] == F7_ALT &&
                 ((opc == OPC_REG && (f3 == 3'd0 || f3 == 3'd5)) ||
                  (opc == OPC_IMM && f3 == 3'd5));
  assign opb   = opc == OPC_REG ? rs2v : i_imm;
  assign sh    = opb[4:0];
  assign addr_ls = rs1v + (opc == OPC_STORE ? s_imm : i_imm);

  always_comb begin
    case (f3)
      3'd0: alu_r = alt ? rs1v - opb : rs1v + opb;
      3'd1: alu_r = rs1v << sh;
      3'd2: alu_r = {31'd0, $signed(rs1v) < $signed(opb)};
      3'd3: alu_r = {31'd0, rs1v < opb};
      3'd4: alu_r = rs1v ^ opb;
      3'd5: alu_r = alt ? 32'($signed(rs1v) >>> sh) : rs1v >> sh;
      3'd6: alu_r = rs1v | opb;
      default: alu_r = rs1v & opb;
    endcase
    case (f3)
      3'd0: taken = rs1v == rs2v;
      3'd1: taken = rs1v != rs2v;
      3'd4: taken = $signed(rs1v) < $signed(rs2v);
      3'd5: taken = $signed(rs1v) >= $signed(rs2v);
      3'd6: taken = rs1v < rs2v;
      3'd7: taken = rs1v >= rs2v;
      default: taken = 1'b0;
    endcase
    case (f3)
      3'd0, 3'd4: lsize = 3'd1;
      3'd1, 3'd5: lsize = 3'd2;
      3'd2: lsize = 3'd4;
      default: lsize = 3'd0;
    endcase
    case (f3)
      3'd0: ssize = 3'd1;
      3'd1: ssize = 3'd2;
      3'd2: ssize = 3'd4;
      default: ssize = 3'd0;
    endcase
  end

  // Load extraction from the registered data word
  logic [OffW-1:0] ls_off;
  logic [31:0] lval;
  assign ls_off = OffW'(addr_ls - MemBase);
  always_comb begin
    case (f3)
      3'd0: lval = {{24{rdata[7]}}, rdata[7:0]};
      3'd1: lval = {{16{rdata[15]}}, rdata[15:0]};
      3'd4: lval = {24'd0, rdata[7:0]};
      3'd5: lval = {16'd0, rdata[15:0]};
      default: lval = rdata;
    endcase
  end

  // Execute-step results
  logic [2:0] ex_st;
  logic       need_mem;
  always_comb begin
    next_pc = pc + 32'd4;
    val = 32'd0;
    wr = 1'b0;
    ex_st = ST_OK;
    need_mem = 1'b0;
    case (opc)
      OPC_LUI:   begin val = u_imm; wr = 1'b1; end
      OPC_AUIPC: begin val = pc + u_imm; wr = 1'b1; end
      OPC_REG, OPC_IMM: begin val = alu_r; wr = 1'b1; end
      OPC_JAL:   begin val = pc + 32'd4; wr = 1'b1; next_pc = pc + j_imm; end
      OPC_JALR:  begin
        val = pc + 32'd4; wr = 1'b1; next_pc = (rs1v + i_imm) & ~32'd1;
      end
      OPC_BRANCH: if (taken) next_pc = pc + b_imm;
      OPC_LOAD: if (lsize != 3'd0) begin
        if (!in_win(addr_ls, lsize)) ex_st = ST_BOUNDS;
        else begin need_mem = 1'b1; wr = 1'b1; val = lval; end
      end
      OPC_STORE: if (ssize != 3'd0) begin
        if (!in_win(addr_ls, ssize)) ex_st = ST_BOUNDS;
        else need_mem = 1'b1;
      end
      OPC_SYSTEM: begin
        if (f3 == 3'd0 && i_imm == 32'd0) ex_st = ST_ECALL;
        else if (f3 == 3'd0 && i_imm == 32'd1) ex_st = ST_EBREAK;
      end
      default: ;
    endcase
    if (ex_st == ST_OK && next_pc[1:0] != 2'b00) ex_st = ST_MISALIGN;
  end

  // Sequencer
  logic [OffW-1:0] pc_off, wa_off;
  logic [3:0] sbe;
  logic       out_free;
  logic       pc_we, reg_we, halt_set, halt_clr, emit;
  logic [31:0] pc_new;
  out_item_t  res_new;

  assign pc_off = OffW'(pc - MemBase);
  assign wa_off = OffW'(q_item.mem_address - MemBase);
  assign out_free = !res_valid || res_take;
  assign sbe = ssize == 3'd1 ? 4'b0001 :
               ssize == 3'd2 ? 4'b0011 : 4'b1111;

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    raddr = pc_off;
    we = 1'b0;
    waddr = wa_off;
    wbe = 4'b1111;
    wdata = q_item.mem_word;
    pc_we = 1'b0; pc_new = pc;
    reg_we = 1'b0; halt_set = 1'b0; halt_clr = 1'b0; emit = 1'b0;
    res_new = '0;
    res_new.executed_pc = pc;
    unique case (state)
      S_IDLE: if (q_valid && out_free) begin
        unique case (q_item.op)
          OP_WRITE: begin
            q_pop = 1'b1; emit = 1'b1;
            if (in_win(q_item.mem_address, 3'd4)) we = 1'b1;
            else res_new.status = ST_BOUNDS;
          end
          OP_START: begin
            q_pop = 1'b1; emit = 1'b1;
            if (entry_pc[1:0] != 2'b00) begin
              res_new.status = ST_MISALIGN; halt_set = 1'b1;
            end else begin
              pc_we = 1'b1; pc_new = entry_pc; halt_clr = 1'b1;
              res_new.executed_pc = entry_pc;
            end
          end
          OP_EXEC: begin
            if (halted) begin
              q_pop = 1'b1; emit = 1'b1; res_new.status = ST_HALTED;
            end else if (pc == 32'd0) begin
              q_pop = 1'b1; emit = 1'b1; res_new.status = ST_PC_ZERO; halt_set = 1'b1;
            end else if (!in_win(pc, 3'd4)) begin
              q_pop = 1'b1; emit = 1'b1; res_new.status = ST_BOUNDS; halt_set = 1'b1;
            end else begin
              state_next = S_FETCH;
            end
          end
          default: begin q_pop = 1'b1; emit = 1'b1; end
        endcase
      end
      S_FETCH: begin
        raddr = ls_off;
        if (need_mem && ex_st == ST_OK) begin
          state_next = S_MEM;
        end else if (out_free) begin
          state_next = S_IDLE; q_pop = 1'b1; emit = 1'b1;
          res_new.instruction_word = w;
          res_new.status = ex_st;
          if (ex_st != ST_OK) halt_set = 1'b1;
          else begin
            pc_we = 1'b1; pc_new = next_pc;
            if (wr && rd != 5'd0) begin
              reg_we = 1'b1; res_new.dest_register = rd; res_new.dest_value = val;
            end
          end
        end else begin
          state_next = S_MEM;
        end
      end
      S_MEM: begin
        raddr = ls_off;
        if (out_free) begin
          state_next = S_IDLE; q_pop = 1'b1; emit = 1'b1;
          res_new.instruction_word = w;
          res_new.status = ex_st;
          if (ex_st != ST_OK) halt_set = 1'b1;
          else begin
            pc_we = 1'b1; pc_new = next_pc;
            if (opc == OPC_STORE) begin
              we = 1'b1; waddr = ls_off; wbe = sbe;
              wdata = rs2v;
            end
            if (wr && rd != 5'd0) begin
              reg_we = 1'b1; res_new.dest_register = rd; res_new.dest_value = val;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    res_new.a0_value = (reg_we && rd == 5'd10) ? val : regs[10];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == S_FETCH) instr <= rdata;
    if (emit) res_item <= res_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 32'd0;
      halted <= 1'b0;
      res_valid <= 1'b0;
      for (int i = 0; i < 32; i++) regs[i] <= 32'd0;
    end else begin
      if (pc_we) pc <= pc_new;
      if (halt_set) halted <= 1'b1;
      else if (halt_clr) halted <= 1'b0;
      if (reg_we) regs[rd] <= val;
      if (emit) res_valid <= 1'b1;
      else if (res_take) res_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) emit |-> q_pop)
    else $error("result without retiring an item");
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("retire without an item");
  assert property (@(posedge clk) disable iff (rst) reg_we |-> rd != 5'd0)
    else $error("write to x0");
  assert property (@(posedge clk) disable iff (rst) (state == S_MEM) |-> $past(state) != S_IDLE)
    else $error("memory step without fetch");

endmodule

@@ src/rv32i_core_step_core.sv @@
// Top level of the RV32I step core: front queue, back end and config register.
// Depends on rvc_pkg, rvc_front and rvc_back.
//
// Usage: items arrive on in_valid/in_stall/in_item; results leave on
// out_valid/out_stall/out_item, exactly one result per item, in order.
// op 0 writes a program word, op 2 starts at entry_pc, op 1 runs one
// instruction. entry_pc is written with cfg_we/cfg_data while idle.
// Flow: write and start items and items with op 3 go from the queue straight
// to the output register; an instruction goes through a fetch read of the
// byte memory, then execute, and loads and stores add a data access on the
// same memory. The memory sits in four byte-wide banks, so an unaligned
// access needs no second access. The back end takes one item at a time: a
// new item waits in the queue until the previous one is retired. A two-entry
// queue separates intake from execution, so items are accepted while a result waits.
// Reset clears the register file, pc, halt flag, queue and output; the
// byte memory keeps whatever it held. When the receiver stalls, the result
// holds in the output register, the back end waits and the queue fills,
// after which in_stall rises.
module rv32i_core_step_core import rvc_pkg::*; #(
  parameter int unsigned MEM_BYTES = MemBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  logic [31:0] entry_pc;
  logic        q_valid, q_pop;
  in_item_t    q_item;

  always_ff @(posedge clk) begin
    if (rst) entry_pc <= EntryPcReset;
    else if (cfg_we) entry_pc <= cfg_data;
  end

  rvc_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  rvc_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk(clk), .rst(rst), .entry_pc(entry_pc),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .res_valid(out_valid), .res_item(out_item), .res_take(!out_stall)
  );

endmodule
